### hdl/subrange_insertion_sorter_unit_assert.svh
// ----------------------------------------------------------------------------
// Subrange insertion sorter assertion macros
// Shared property shapes for the checker of the sorter unit.
// ----------------------------------------------------------------------------
`ifndef SUBRANGE_INSERTION_SORTER_UNIT_ASSERT_SVH
`define SUBRANGE_INSERTION_SORTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIS_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SIS_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sis_pkg.sv
// ----------------------------------------------------------------------------
// Subrange insertion sorter package
// Widths, register indexes and the command and status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sis_pkg;

  // Element and configuration widths.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 1'd1;

  // Register reset values.
  localparam logic [CFG_W-1:0] RANGE_START_RST = 6'd0;
  localparam logic [CFG_W-1:0] RANGE_END_RST   = 6'd63;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_en;   // input channel open, store the word on a handshake
    logic start;     // latch bounds and error flag, set the first position, clear emit index
    logic key_rd;    // read the key at the current position
    logic key_cap;   // capture the key, read its left neighbor
    logic shift;     // move the neighbor one place right, read the next one
    logic place;     // write the key into its slot
    logic pos_inc;   // advance to the next position
    logic emit_rd;   // read the element to be emitted
    logic emit_ld;   // load the output register
    logic clear;     // empty the store
  } sis_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic in_final;
    logic sort_go;       // bounds in range and start below end
    logic less;          // key below the neighbor just read
    logic slot_next_lo;  // a shift now lands the slot on the low bound
    logic pos_at_hi;     // current position is the high bound
    logic out_free;      // output register empty or being taken
    logic emit_last;     // emit index is the last loaded position
  } sis_status_t;

endpackage

### hdl/sis_if.sv
// ----------------------------------------------------------------------------
// Subrange insertion sorter stream interfaces
// Valid/ready channels for loaded elements and for emitted results.
// ----------------------------------------------------------------------------
interface sis_in_if;
  import sis_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] element;
  logic                     final_element;

  modport source (output valid, element, final_element, input ready);
  modport sink (input valid, element, final_element, output ready);
endinterface

interface sis_out_if;
  import sis_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_element;
  logic                     final_result;
  logic                     range_error;

  modport source (output valid, sorted_element, final_result, range_error, input ready);
  modport sink (input valid, sorted_element, final_result, range_error, output ready);
endinterface

### hdl/sis_datapath.sv
// ----------------------------------------------------------------------------
// Subrange insertion sorter datapath
// Element store, key and neighbor registers, position counters, the bound
// registers and the output register.
// ----------------------------------------------------------------------------
module sis_datapath #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sis_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sis_pkg::CFG_W-1:0]           cfg_data_i,
  input  sis_pkg::sis_cmd_t                   cmd_i,
  output sis_pkg::sis_status_t                status_o,
  sis_in_if.sink                              in_i,
  sis_out_if.source                           out_o
);
  import sis_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW   = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CMPW = (CW > CFG_W) ? CW : CFG_W;

  // Element store.
  logic [DATA_W-1:0] mem [MAX_ELEMENTS];

  logic signed [DATA_W-1:0] rd_data_q;
  logic signed [DATA_W-1:0] key_q;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [DATA_W-1:0]        wr_data;

  logic [CFG_W-1:0] start_q, end_q;
  logic [CW-1:0]    count_q;
  logic [AW-1:0]    pos_q, slot_q, lo_q, hi_q, k_q;
  logic             err_q;
  logic             out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  logic             out_last_q;
  logic             out_err_q;

  logic load_hs;
  logic count_full;
  logic bound_err;

  assign load_hs    = cmd_i.load_en && in_i.valid;
  assign count_full = (count_q == CW'(MAX_ELEMENTS));
  assign bound_err  = (CMPW'(start_q) >= CMPW'(count_q)) || (CMPW'(end_q) >= CMPW'(count_q));

  // Read address: key, left neighbor, next neighbor while shifting, or emit.
  always_comb begin
    rd_addr = pos_q;
    if (cmd_i.key_cap) begin
      rd_addr = slot_q - AW'(1);
    end else if (cmd_i.shift) begin
      rd_addr = slot_q - AW'(2);
    end else if (cmd_i.emit_rd) begin
      rd_addr = k_q;
    end
  end

  // Write port: loaded word, shifted neighbor or placed key.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_q;
    wr_data = key_q;
    if (load_hs && !count_full) begin
      wr_en   = 1'b1;
      wr_addr = count_q[AW-1:0];
      wr_data = in_i.element;
    end else if (cmd_i.shift) begin
      wr_en   = 1'b1;
      wr_data = rd_data_q;
    end else if (cmd_i.place) begin
      wr_en   = 1'b1;
    end
  end

  // Store with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= RANGE_START_RST;
      end_q   <= RANGE_END_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RANGE_START: start_q <= cfg_data_i;
        REG_RANGE_END:   end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Fill count, position counters and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pos_q       <= '0;
      slot_q      <= '0;
      k_q         <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_hs && !count_full) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end
      if (cmd_i.start) begin
        err_q <= bound_err;
        pos_q <= AW'(start_q) + AW'(1);
        k_q   <= '0;
      end
      if (cmd_i.key_rd) begin
        slot_q <= pos_q;
      end
      if (cmd_i.shift) begin
        slot_q <= slot_q - AW'(1);
      end
      if (cmd_i.pos_inc) begin
        pos_q <= pos_q + AW'(1);
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.emit_ld) begin
        out_valid_q <= 1'b1;
        k_q         <= k_q + AW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      lo_q <= AW'(start_q);
      hi_q <= AW'(end_q);
    end
    if (cmd_i.key_cap) begin
      key_q <= rd_data_q;
    end
    if (cmd_i.emit_ld) begin
      out_data_q <= rd_data_q;
      out_last_q <= status_o.emit_last;
      out_err_q  <= err_q;
    end
  end

  // Status toward the controller.
  assign status_o.in_valid     = in_i.valid;
  assign status_o.in_final     = in_i.final_element;
  assign status_o.sort_go      = !bound_err && (start_q < end_q);
  assign status_o.less         = key_q < rd_data_q;
  assign status_o.slot_next_lo = (slot_q - AW'(1)) == lo_q;
  assign status_o.pos_at_hi    = pos_q == hi_q;
  assign status_o.out_free     = !out_valid_q || out_o.ready;
  assign status_o.emit_last    = (CW'(k_q) + CW'(1)) == count_q;

  // Channel drive.
  assign in_i.ready           = cmd_i.load_en;
  assign out_o.valid          = out_valid_q;
  assign out_o.sorted_element = out_data_q;
  assign out_o.final_result   = out_last_q;
  assign out_o.range_error    = out_err_q;

endmodule

### hdl/sis_controller.sv
// ----------------------------------------------------------------------------
// Subrange insertion sorter controller
// Sequences loading, the insertion passes over the store and the emission of
// the result words.
// ----------------------------------------------------------------------------
module sis_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sis_pkg::sis_status_t status_i,
  output sis_pkg::sis_cmd_t    cmd_o
);
  import sis_pkg::*;

  localparam logic [2:0] ST_LOAD    = 3'd0;
  localparam logic [2:0] ST_DECIDE  = 3'd1;
  localparam logic [2:0] ST_KEY_RD  = 3'd2;
  localparam logic [2:0] ST_KEY_CAP = 3'd3;
  localparam logic [2:0] ST_CMP     = 3'd4;
  localparam logic [2:0] ST_PLACE   = 3'd5;
  localparam logic [2:0] ST_EMIT_RD = 3'd6;
  localparam logic [2:0] ST_EMIT_LD = 3'd7;

  logic [2:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_LOAD: begin
        cmd_o.load_en = 1'b1;
        if (status_i.in_valid && status_i.in_final) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.start = 1'b1;
        state_d = status_i.sort_go ? ST_KEY_RD : ST_EMIT_RD;
      end
      ST_KEY_RD: begin
        cmd_o.key_rd = 1'b1;
        state_d = ST_KEY_CAP;
      end
      ST_KEY_CAP: begin
        cmd_o.key_cap = 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (status_i.less) begin
          cmd_o.shift = 1'b1;
          if (status_i.slot_next_lo) begin
            state_d = ST_PLACE;
          end
        end else begin
          cmd_o.place = 1'b1;
          if (status_i.pos_at_hi) begin
            state_d = ST_EMIT_RD;
          end else begin
            cmd_o.pos_inc = 1'b1;
            state_d = ST_KEY_RD;
          end
        end
      end
      ST_PLACE: begin
        cmd_o.place = 1'b1;
        if (status_i.pos_at_hi) begin
          state_d = ST_EMIT_RD;
        end else begin
          cmd_o.pos_inc = 1'b1;
          state_d = ST_KEY_RD;
        end
      end
      ST_EMIT_RD: begin
        if (status_i.out_free) begin
          cmd_o.emit_rd = 1'b1;
          state_d = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        cmd_o.emit_ld = 1'b1;
        if (status_i.emit_last) begin
          cmd_o.clear = 1'b1;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_EMIT_RD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/subrange_insertion_sorter_unit.sv
// ----------------------------------------------------------------------------
// Subrange insertion sorter unit
// Loads a set of signed words, insertion-sorts a configured subrange of
// positions in place and streams the whole set back out in position order.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one word per handshake; final_element closes the set. Words
//   beyond MAX_ELEMENTS are dropped, the closing word still closes the set.
//   Loading takes one word per cycle. After the closing word the unit stops
//   taking input, checks the bounds and sorts positions range_start through
//   range_end in the store: each position reads its key, moves every larger
//   word on its left one place right and writes the key into the gap.
//   A bound at or above the loaded count skips the sort and flags every
//   result with range_error.
//   out_o then carries the words in position order through the store's registered
//   read port, with final_result on the last one. The output register holds a
//   word while out_o.ready is low and the sequencer waits; the unit takes the
//   next set as soon as the last word sits in the output register.
//   Reset puts the unit in loading with an empty store, range_start 0 and
//   range_end 63. Write range_start and range_end through cfg_we_i only while
//   the unit is idle.
// ----------------------------------------------------------------------------
module subrange_insertion_sorter_unit #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sis_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sis_pkg::CFG_W-1:0]     cfg_data_i,
  sis_in_if.sink                        in_i,
  sis_out_if.source                     out_o
);
  import sis_pkg::*;

  sis_cmd_t    cmd;
  sis_status_t status;

  // Sequencer.
  sis_controller u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Store, counters and output register.
  sis_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_i       (in_i),
    .out_o      (out_o)
  );

endmodule

### hdl/sis_checker.sv
// ----------------------------------------------------------------------------
// Subrange insertion sorter checker
// Port-level properties of the sorter unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "subrange_insertion_sorter_unit_assert.svh"

module sis_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_final_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [sis_pkg::DATA_W-1:0] out_data_i,
  input logic                      out_last_i,
  input logic                      out_err_i
);
  import sis_pkg::*;

  // A stalled result word keeps its value.
  `SIS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(out_data_i), "result word changed while stalled")

  // The closing word stops the input for at least the bound check.
  `SIS_ASSERT_NEXT(a_close_stops_input, clk_i, rst_ni,
                   in_valid_i && in_ready_i && in_final_i, !in_ready_i,
                   "input taken right after the closing word")

  // The input stays closed while a set is still being emitted.
  `SIS_ASSERT_IMPL(a_no_load_mid_emit, clk_i, rst_ni, out_valid_i && !out_last_i,
                   !in_ready_i, "input open before the last result was loaded")

  // The error flag holds from one word of a set to the next.
  `SIS_ASSERT_NEXT(a_err_steady, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_i,
                   $stable(out_err_i), "range error flag changed within a set")

endmodule

bind subrange_insertion_sorter_unit sis_checker u_sis_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_final_i  (in_i.final_element),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.sorted_element),
  .out_last_i  (out_o.final_result),
  .out_err_i   (out_o.range_error)
);
